[rtl/m65_pkg.sv]
// shared types and instruction codes for the 6502 execute unit
package m65_pkg;

  localparam int unsigned OP_W   = 6;
  localparam int unsigned BYTE_W = 8;

  // status register bit positions
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [BYTE_W-1:0] SIGN_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] ALL_ONES  = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
    OP_STX = 6'd4,  OP_STY = 6'd5,  OP_TAX = 6'd6,  OP_TAY = 6'd7,
    OP_TXA = 6'd8,  OP_TYA = 6'd9,  OP_TSX = 6'd10, OP_TXS = 6'd11,
    OP_AND = 6'd12, OP_EOR = 6'd13, OP_ORA = 6'd14, OP_BIT = 6'd15,
    OP_ADC = 6'd16, OP_SBC = 6'd17, OP_CMP = 6'd18, OP_CPX = 6'd19,
    OP_CPY = 6'd20, OP_INC = 6'd21, OP_INX = 6'd22, OP_INY = 6'd23,
    OP_DEC = 6'd24, OP_DEX = 6'd25, OP_DEY = 6'd26, OP_ASL = 6'd27,
    OP_LSR = 6'd28, OP_ROL = 6'd29, OP_ROR = 6'd30, OP_CLC = 6'd31,
    OP_CLD = 6'd32, OP_CLI = 6'd33, OP_CLV = 6'd34, OP_SEC = 6'd35,
    OP_SED = 6'd36, OP_SEI = 6'd37, OP_NOP = 6'd38
  } op_t;

  // architectural register set
  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] y;
    logic [BYTE_W-1:0] sp;
    logic [BYTE_W-1:0] p;
  } arch_t;

  // memory write request from the execute logic
  typedef struct packed {
    logic              we;
    logic [BYTE_W-1:0] wd;
  } mem_wr_t;

endpackage

[rtl/m65_if.sv]
// request and result channel interfaces
interface m65_req_if import m65_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   req_type;
  logic [BYTE_W-1:0] operand;
  logic              on_accumulator;

  modport source (output valid, req_type, operand, on_accumulator, input ready);
  modport sink   (input valid, req_type, operand, on_accumulator, output ready);
endinterface

interface m65_rsp_if import m65_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [BYTE_W-1:0] write_data;
  logic [BYTE_W-1:0] acc_value;
  logic [BYTE_W-1:0] x_value;
  logic [BYTE_W-1:0] y_value;
  logic [BYTE_W-1:0] sp_value;
  logic [BYTE_W-1:0] status_value;

  modport source (output valid, write_enable, write_data, acc_value, x_value, y_value,
                  sp_value, status_value, input ready);
  modport sink   (input valid, write_enable, write_data, acc_value, x_value, y_value,
                  sp_value, status_value, output ready);
endinterface

[rtl/mos6502_alu_register_execute.sv]
// top level of the 6502 execute unit: request register, state and result register
// One instruction is taken per clock while the result side keeps draining. A
// request is captured in the request register on acceptance, executed through
// the 8-bit adder, shifter and flag logic against A, X, Y, SP and P, and its
// result (the registers after the step plus an optional memory write byte) is
// loaded into the result register when that slot is free or draining. Sustained
// rate is one request per cycle while the result side accepts; the request side
// keeps accepting while a result waits, and stops only when both the request
// register and the result register are full. The valid flags and the registers
// A, X, Y, SP and P reset to zero.
module mos6502_alu_register_execute import m65_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  m65_req_if.sink   in_req,
  m65_rsp_if.source out_rsp
);

  logic              req_valid_r;
  logic [OP_W-1:0]   req_op_r;
  logic [BYTE_W-1:0] req_operand_r;
  logic              req_on_acc_r;
  logic              advance;

  arch_t             arch_r;
  arch_t             arch_nxt;
  mem_wr_t           wr_nxt;

  logic              out_valid_r;
  mem_wr_t           out_wr_r;
  arch_t             out_arch_r;

  // request moves to the result register when that slot is free or draining
  assign advance      = req_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !req_valid_r || advance;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_op_r      <= in_req.req_type;
      req_operand_r <= in_req.operand;
      req_on_acc_r  <= in_req.on_accumulator;
    end
  end

  // execute logic
  m65_exec u_exec (
    .op      (req_op_r),
    .operand (req_operand_r),
    .on_acc  (req_on_acc_r),
    .cur     (arch_r),
    .nxt     (arch_nxt),
    .wr      (wr_nxt)
  );

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r <= '0;
    end else if (advance) begin
      arch_r <= arch_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_wr_r   <= wr_nxt;
      out_arch_r <= arch_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.write_enable = out_wr_r.we;
  assign out_rsp.write_data   = out_wr_r.wd;
  assign out_rsp.acc_value    = out_arch_r.a;
  assign out_rsp.x_value      = out_arch_r.x;
  assign out_rsp.y_value      = out_arch_r.y;
  assign out_rsp.sp_value     = out_arch_r.sp;
  assign out_rsp.status_value = out_arch_r.p;

  // no request is taken while the request register is full and blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && !advance) |-> !in_req.ready)
    else $error("request taken while request register is blocked");

  // bits 4 and 5 of the status register never change from reset
  a_status_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
    arch_r.p[5:4] == 2'b00)
    else $error("status bits 4 or 5 changed");

  // a transfer to the stack pointer leaves the flags alone
  a_txs_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && req_op_r == OP_TXS) |=> (arch_r.p == $past(arch_r.p)))
    else $error("flags changed by transfer to stack pointer");

  // the presented result matches the architectural state it produced
  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) |-> (out_arch_r == arch_r))
    else $error("result register out of step with registers");

  // memory write data is zero when no write is requested
  a_idle_write_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wr_r.we) |-> (out_wr_r.wd == '0))
    else $error("write data nonzero without write enable");

endmodule

[rtl/m65_exec.sv]
// combinational execute logic: registers, alu, shifter and flag rules
module m65_exec import m65_pkg::*; (
  input  logic [OP_W-1:0]   op,
  input  logic [BYTE_W-1:0] operand,
  input  logic              on_acc,
  input  arch_t             cur,
  output arch_t             nxt,
  output mem_wr_t           wr
);

  logic [BYTE_W-1:0] add_m;
  logic [BYTE_W:0]   sum;
  logic [BYTE_W-1:0] cmp_r;
  logic [BYTE_W:0]   diff;
  logic [BYTE_W-1:0] sh_src;
  logic [BYTE_W-1:0] sh_res;
  logic              sh_c;
  logic [BYTE_W-1:0] zn_val;
  logic              upd_zn;

  // adder shared by adc and sbc (sbc adds the inverted operand)
  assign add_m = (op == OP_SBC) ? ~operand : operand;
  assign sum   = {1'b0, cur.a} + {1'b0, add_m} + {{BYTE_W{1'b0}}, cur.p[FL_C]};

  // compare subtractor, register picked by opcode
  always_comb begin
    priority case (op)
      OP_CPX:  cmp_r = cur.x;
      OP_CPY:  cmp_r = cur.y;
      default: cmp_r = cur.a;
    endcase
  end
  assign diff = {1'b0, cmp_r} - {1'b0, operand};

  // shifter and rotator
  assign sh_src = on_acc ? cur.a : operand;
  always_comb begin
    unique case (op)
      OP_ASL: begin
        sh_res = {sh_src[BYTE_W-2:0], 1'b0};
        sh_c   = sh_src[BYTE_W-1];
      end
      OP_ROL: begin
        sh_res = {sh_src[BYTE_W-2:0], cur.p[FL_C]};
        sh_c   = sh_src[BYTE_W-1];
      end
      OP_ROR: begin
        sh_res = {cur.p[FL_C], sh_src[BYTE_W-1:1]};
        sh_c   = sh_src[0];
      end
      default: begin
        sh_res = {1'b0, sh_src[BYTE_W-1:1]};
        sh_c   = sh_src[0];
      end
    endcase
  end

  // instruction decode and register update
  always_comb begin
    nxt    = cur;
    wr.we  = 1'b0;
    wr.wd  = '0;
    zn_val = '0;
    upd_zn = 1'b0;
    unique case (op)
      OP_LDA: begin nxt.a = operand; zn_val = operand; upd_zn = 1'b1; end
      OP_LDX: begin nxt.x = operand; zn_val = operand; upd_zn = 1'b1; end
      OP_LDY: begin nxt.y = operand; zn_val = operand; upd_zn = 1'b1; end
      OP_STA: begin wr.we = 1'b1; wr.wd = cur.a; end
      OP_STX: begin wr.we = 1'b1; wr.wd = cur.x; end
      OP_STY: begin wr.we = 1'b1; wr.wd = cur.y; end
      OP_TAX: begin nxt.x = cur.a;  zn_val = cur.a;  upd_zn = 1'b1; end
      OP_TAY: begin nxt.y = cur.a;  zn_val = cur.a;  upd_zn = 1'b1; end
      OP_TXA: begin nxt.a = cur.x;  zn_val = cur.x;  upd_zn = 1'b1; end
      OP_TYA: begin nxt.a = cur.y;  zn_val = cur.y;  upd_zn = 1'b1; end
      OP_TSX: begin nxt.x = cur.sp; zn_val = cur.sp; upd_zn = 1'b1; end
      OP_TXS: nxt.sp = cur.x;
      OP_AND: begin
        nxt.a = cur.a & operand; zn_val = cur.a & operand; upd_zn = 1'b1;
      end
      OP_EOR: begin
        nxt.a = cur.a ^ operand; zn_val = cur.a ^ operand; upd_zn = 1'b1;
      end
      OP_ORA: begin
        nxt.a = cur.a | operand; zn_val = cur.a | operand; upd_zn = 1'b1;
      end
      OP_BIT: begin
        nxt.p[FL_Z] = ((cur.a & operand) == '0);
        nxt.p[FL_V] = operand[FL_V];
        nxt.p[FL_N] = operand[FL_N];
      end
      OP_ADC, OP_SBC: begin
        nxt.a       = sum[BYTE_W-1:0];
        nxt.p[FL_C] = sum[BYTE_W];
        nxt.p[FL_V] = |(~(cur.a ^ add_m) & (cur.a ^ sum[BYTE_W-1:0]) & SIGN_MASK);
        zn_val      = sum[BYTE_W-1:0];
        upd_zn      = 1'b1;
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.p[FL_C] = ~diff[BYTE_W];
        zn_val      = diff[BYTE_W-1:0];
        upd_zn      = 1'b1;
      end
      OP_INC: begin
        wr.we = 1'b1; wr.wd = operand + 8'd1; zn_val = operand + 8'd1; upd_zn = 1'b1;
      end
      OP_DEC: begin
        wr.we = 1'b1; wr.wd = operand + ALL_ONES; zn_val = operand + ALL_ONES;
        upd_zn = 1'b1;
      end
      OP_INX: begin nxt.x = cur.x + 8'd1;    zn_val = cur.x + 8'd1;    upd_zn = 1'b1; end
      OP_INY: begin nxt.y = cur.y + 8'd1;    zn_val = cur.y + 8'd1;    upd_zn = 1'b1; end
      OP_DEX: begin nxt.x = cur.x + ALL_ONES; zn_val = cur.x + ALL_ONES; upd_zn = 1'b1; end
      OP_DEY: begin nxt.y = cur.y + ALL_ONES; zn_val = cur.y + ALL_ONES; upd_zn = 1'b1; end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        nxt.p[FL_C] = sh_c;
        zn_val      = sh_res;
        upd_zn      = 1'b1;
        if (on_acc) begin
          nxt.a = sh_res;
        end else begin
          wr.we = 1'b1;
          wr.wd = sh_res;
        end
      end
      OP_CLC: nxt.p[FL_C] = 1'b0;
      OP_CLD: nxt.p[FL_D] = 1'b0;
      OP_CLI: nxt.p[FL_I] = 1'b0;
      OP_CLV: nxt.p[FL_V] = 1'b0;
      OP_SEC: nxt.p[FL_C] = 1'b1;
      OP_SED: nxt.p[FL_D] = 1'b1;
      OP_SEI: nxt.p[FL_I] = 1'b1;
      OP_NOP: ;
      default: ;
    endcase
    // zero and negative from the result byte
    if (upd_zn) begin
      nxt.p[FL_Z] = (zn_val == '0);
      nxt.p[FL_N] = zn_val[BYTE_W-1];
    end
  end

endmodule
